// ----- hdl/xpbd_pkg.sv -----
// Shared types, codes and helper functions of the distance-constraint solver.
`timescale 1ns / 1ps
`default_nettype none
package xpbd_pkg;

	// Operation codes of a request
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SOLVE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Outcome codes of a result
	localparam logic [2:0] OUTCOME_WRITTEN    = 3'd0;
	localparam logic [2:0] OUTCOME_APPLIED    = 3'd1;
	localparam logic [2:0] OUTCOME_PINNED     = 3'd2;
	localparam logic [2:0] OUTCOME_COINCIDENT = 3'd3;
	localparam logic [2:0] OUTCOME_READ       = 3'd4;

	localparam logic [31:0] TIME_STEP_RESET = 32'd1092;
	localparam logic [31:0] ALPHA_MAX       = 32'hFFFF_FFFF;
	localparam logic [30:0] MAG31_MAX       = 31'h7FFF_FFFF;

	// Divider iteration counts
	localparam logic [5:0] ALPHA_ITERS  = 6'd32;
	localparam logic [5:0] LAMBDA_ITERS = 6'd31;
	localparam logic [5:0] DIR_ITERS    = 6'd17;

	typedef struct packed {
		logic [1:0]         operation;
		logic [9:0]         first_particle;
		logic [9:0]         second_particle;
		logic signed [31:0] load_x;
		logic signed [31:0] load_y;
		logic signed [31:0] load_z;
		logic [31:0]        load_inverse_mass;
		logic [30:0]        rest_length;
		logic [31:0]        compliance;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [31:0]        out_inverse_mass;
		logic [2:0]         outcome;
	} rsp_item_t;

	// Datapath commands
	typedef enum logic [4:0] {
		CMD_IDLE, CMD_LOAD, CMD_WRITE, CMD_READ_A, CMD_READ_B, CMD_CAP_B,
		CMD_DELTA, CMD_SQUARE, CMD_SQRT_INIT, CMD_SQRT_STEP, CMD_DIST,
		CMD_ALPHA_START, CMD_ALPHA_WAIT, CMD_LM_START, CMD_LM_WAIT,
		CMD_DIR_START, CMD_DIR_WAIT, CMD_STEP, CMD_MOVE, CMD_STORE, CMD_RESULT
	} dp_code_t;

	typedef struct packed {
		dp_code_t   code;
		logic [1:0] axis;
		logic       end_b;
		logic [2:0] outcome;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] operation;
		logic       wsum_zero;
		logic       s_zero;
		logic       sqrt_last;
		logic       div_done;
		logic       alpha_skip;
		logic       lm_sat;
	} dp_stat_t;

	// Saturate a 33-bit signed value to 32 bits
	function automatic logic [31:0] sat32(input logic [32:0] v);
		logic [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Magnitude of a 32-bit signed value
	function automatic logic [31:0] mag32(input logic [31:0] v);
		logic [31:0] r;
		r = v[31] ? (~v + 32'd1) : v;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/xpbd_if.sv -----
// Request and result channel interfaces of the distance-constraint solver.
`timescale 1ns / 1ps
`default_nettype none
interface xpbd_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [9:0]         first_particle;
	logic [9:0]         second_particle;
	logic signed [31:0] load_x;
	logic signed [31:0] load_y;
	logic signed [31:0] load_z;
	logic [31:0]        load_inverse_mass;
	logic [30:0]        rest_length;
	logic [31:0]        compliance;

	modport source (
		output valid, operation, first_particle, second_particle, load_x, load_y,
		       load_z, load_inverse_mass, rest_length, compliance,
		input  ready
	);
	modport sink (
		input  valid, operation, first_particle, second_particle, load_x, load_y,
		       load_z, load_inverse_mass, rest_length, compliance,
		output ready
	);
endinterface

interface xpbd_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic [31:0]        out_inverse_mass;
	logic [2:0]         outcome;

	modport source (
		output valid, out_x, out_y, out_z, out_inverse_mass, outcome,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, out_inverse_mass, outcome,
		output ready
	);
endinterface
`default_nettype wire

// ----- hdl/xpbd_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module xpbd_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num_hi,
	input  wire logic [63:0] num_lo,
	input  wire logic [63:0] den,
	input  wire logic [5:0]  iters,
	output logic [31:0]      quotient,
	output logic             done
);
	logic [64:0] rem_q;
	logic [63:0] lo_q;
	logic [63:0] den_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] shifted;
	logic        fits;

	// Shift in the next numerator bit and trial-subtract
	assign shifted = {rem_q[63:0], lo_q[63]};
	assign fits    = shifted >= {1'b0, den_q};

	// Advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 6'd1;
			busy_q <= cnt_q != 6'd1;
			done_q <= cnt_q == 6'd1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// Iterate remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num_hi};
			lo_q  <= num_lo;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
			lo_q  <= {lo_q[62:0], 1'b0};
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule
`default_nettype wire

// ----- hdl/xpbd_dp.sv -----
// Datapath: particle memory, square root, divider and position update.
`timescale 1ns / 1ps
`default_nettype none
module xpbd_dp #(
	parameter int PARTICLE_COUNT = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire xpbd_pkg::dp_cmd_t  cmd,
	output xpbd_pkg::dp_stat_t      stat,
	input  wire xpbd_pkg::req_item_t req_item,
	output xpbd_pkg::rsp_item_t     rsp_item,
	input  wire logic               cfg_write_enable,
	input  wire logic [31:0]        cfg_write_data
);
	import xpbd_pkg::*;

	localparam int ADDR_W = $clog2(PARTICLE_COUNT);

	req_item_t   item_q;
	rsp_item_t   rsp_q;
	logic [31:0] time_step_q;

	logic [127:0] mem [PARTICLE_COUNT];
	logic [127:0] rd_q;
	logic         mem_we;
	logic         mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [127:0] mem_wdata;

	logic [31:0] pa_q [3];
	logic [31:0] pb_q [3];
	logic [31:0] d_q  [3];
	logic [31:0] np_q [3];
	logic [16:0] dm_q [3];
	logic [31:0] wa_q, wb_q;
	logic [63:0] dt2_q;
	logic [63:0] s_q;
	logic [31:0] dist_q;
	logic [31:0] cmag_q;
	logic        lneg_q;
	logic [31:0] alpha_q;
	logic [30:0] lm_q;
	logic [30:0] step_q;

	logic [33:0] sq_rem_q;
	logic [31:0] sq_root_q;
	logic [63:0] sq_bits_q;
	logic [4:0]  sq_cnt_q;

	logic        va, vb;
	logic [31:0] dmag;
	logic [63:0] sq_prod;
	logic [33:0] sq_t, sq_trial;
	logic [34:0] den35;
	logic        alpha_zero, alpha_sat, lm_sat;
	logic [62:0] step_prod;
	logic [46:0] step_sh;
	logic [47:0] mv_prod;
	logic [32:0] pos_ext, mv_ext, pos_sum;
	logic        move_neg;
	logic        div_start;
	logic [63:0] div_hi, div_lo, div_den;
	logic [5:0]  div_iters;
	logic [31:0] div_q;
	logic        div_done;

	// Decode particle validity
	assign va = {22'd0, item_q.first_particle} < 32'(PARTICLE_COUNT);
	assign vb = {22'd0, item_q.second_particle} < 32'(PARTICLE_COUNT);

	// Hold the time step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RESET;
		end else if (cfg_write_enable) begin
			time_step_q <= cfg_write_data;
		end
	end

	// Select the memory access
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = ADDR_W'(item_q.first_particle);
		mem_wdata = {item_q.load_x, item_q.load_y, item_q.load_z,
		             item_q.load_inverse_mass};
		unique case (cmd.code)
			CMD_WRITE: mem_we = va;
			CMD_READ_A: mem_re = 1'b1;
			CMD_READ_B: begin
				mem_re   = 1'b1;
				mem_addr = ADDR_W'(item_q.second_particle);
			end
			CMD_STORE: begin
				mem_we    = cmd.end_b ? vb : va;
				mem_addr  = cmd.end_b ? ADDR_W'(item_q.second_particle)
				                      : ADDR_W'(item_q.first_particle);
				mem_wdata = {np_q[0], np_q[1], np_q[2], cmd.end_b ? wb_q : wa_q};
			end
			default: ;
		endcase
	end

	// Access the particle memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	// Square one delta component
	assign dmag    = mag32(d_q[cmd.axis]);
	assign sq_prod = {32'd0, dmag} * {32'd0, dmag};

	// Square-root trial subtract
	assign sq_t     = {sq_rem_q[31:0], sq_bits_q[63:62]};
	assign sq_trial = {sq_root_q, 2'b01};

	// Constraint denominator and saturation checks
	assign den35      = {3'd0, wa_q} + {3'd0, wb_q} + {3'd0, alpha_q};
	assign alpha_zero = item_q.compliance == 32'd0;
	assign alpha_sat  = {32'd0, item_q.compliance} >= dt2_q;
	assign lm_sat     = {18'd0, cmag_q} >= {den35, 15'd0};

	// Step length for one end and move for one axis
	assign step_prod = {32'd0, lm_q} * {31'd0, (cmd.end_b ? wb_q : wa_q)};
	assign step_sh   = step_prod[62:16];
	assign mv_prod   = {31'd0, dm_q[cmd.axis]} * {17'd0, step_q};
	assign pos_ext   = cmd.end_b ? {pb_q[cmd.axis][31], pb_q[cmd.axis]}
	                             : {pa_q[cmd.axis][31], pa_q[cmd.axis]};
	assign mv_ext    = {1'b0, mv_prod[47:16]};
	assign move_neg  = d_q[cmd.axis][31] ^ lneg_q ^ !cmd.end_b;
	assign pos_sum   = move_neg ? (pos_ext - mv_ext) : (pos_ext + mv_ext);

	// Feed the divider
	always_comb begin
		div_start = 1'b0;
		div_hi    = {32'd0, item_q.compliance};
		div_lo    = '0;
		div_den   = dt2_q;
		div_iters = ALPHA_ITERS;
		unique case (cmd.code)
			CMD_ALPHA_START: div_start = !alpha_zero && !alpha_sat;
			CMD_LM_START: begin
				div_start = !lm_sat;
				div_hi    = {47'd0, cmag_q[31:15]};
				div_lo    = {cmag_q[14:0], 49'd0};
				div_den   = {29'd0, den35};
				div_iters = LAMBDA_ITERS;
			end
			CMD_DIR_START: begin
				div_start = 1'b1;
				div_hi    = {33'd0, dmag[31:1]};
				div_lo    = {dmag[0], 63'd0};
				div_den   = {32'd0, dist_q};
				div_iters = DIR_ITERS;
			end
			default: ;
		endcase
	end

	xpbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num_hi   (div_hi),
		.num_lo   (div_lo),
		.den      (div_den),
		.iters    (div_iters),
		.quotient (div_q),
		.done     (div_done)
	);

	// Advance the square-root counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (cmd.code == CMD_SQRT_INIT) begin
			sq_cnt_q <= '0;
		end else if (cmd.code == CMD_SQRT_STEP) begin
			sq_cnt_q <= sq_cnt_q + 5'd1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (cmd.code)
			CMD_LOAD: item_q <= req_item;
			CMD_READ_B: begin
				pa_q[0] <= va ? rd_q[127:96] : 32'd0;
				pa_q[1] <= va ? rd_q[95:64]  : 32'd0;
				pa_q[2] <= va ? rd_q[63:32]  : 32'd0;
				wa_q    <= va ? rd_q[31:0]   : 32'd0;
			end
			CMD_CAP_B: begin
				pb_q[0] <= vb ? rd_q[127:96] : 32'd0;
				pb_q[1] <= vb ? rd_q[95:64]  : 32'd0;
				pb_q[2] <= vb ? rd_q[63:32]  : 32'd0;
				wb_q    <= vb ? rd_q[31:0]   : 32'd0;
			end
			CMD_DELTA: begin
				for (int i = 0; i < 3; i++) begin
					d_q[i] <= sat32({pb_q[i][31], pb_q[i]} - {pa_q[i][31], pa_q[i]});
				end
				dt2_q <= {32'd0, time_step_q} * {32'd0, time_step_q};
				s_q   <= '0;
			end
			CMD_SQUARE: s_q <= s_q + sq_prod;
			CMD_SQRT_INIT: begin
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				sq_bits_q <= s_q;
			end
			CMD_SQRT_STEP: begin
				if (sq_t >= sq_trial) begin
					sq_rem_q  <= sq_t - sq_trial;
					sq_root_q <= {sq_root_q[30:0], 1'b1};
				end else begin
					sq_rem_q  <= sq_t;
					sq_root_q <= {sq_root_q[30:0], 1'b0};
				end
				sq_bits_q <= {sq_bits_q[61:0], 2'b00};
			end
			CMD_DIST: begin
				dist_q <= sq_root_q;
				cmag_q <= (sq_root_q >= {1'b0, item_q.rest_length})
				          ? sq_root_q - {1'b0, item_q.rest_length}
				          : {1'b0, item_q.rest_length} - sq_root_q;
				lneg_q <= sq_root_q > {1'b0, item_q.rest_length};
			end
			CMD_ALPHA_START: begin
				if (alpha_zero) begin
					alpha_q <= '0;
				end else if (alpha_sat) begin
					alpha_q <= ALPHA_MAX;
				end
			end
			CMD_ALPHA_WAIT: begin
				if (div_done) begin
					alpha_q <= div_q;
				end
			end
			CMD_LM_START: begin
				if (lm_sat) begin
					lm_q <= MAG31_MAX;
				end
			end
			CMD_LM_WAIT: begin
				if (div_done) begin
					lm_q <= div_q[30:0];
				end
			end
			CMD_DIR_WAIT: begin
				if (div_done) begin
					dm_q[cmd.axis] <= div_q[16:0];
				end
			end
			CMD_STEP: step_q <= (|step_sh[46:31]) ? MAG31_MAX : step_sh[30:0];
			CMD_MOVE: np_q[cmd.axis] <= sat32(pos_sum);
			CMD_RESULT: begin
				rsp_q.outcome <= cmd.outcome;
				if (item_q.operation != OP_WRITE && item_q.operation != OP_SOLVE && va) begin
					rsp_q.out_x            <= rd_q[127:96];
					rsp_q.out_y            <= rd_q[95:64];
					rsp_q.out_z            <= rd_q[63:32];
					rsp_q.out_inverse_mass <= rd_q[31:0];
				end else begin
					rsp_q.out_x            <= '0;
					rsp_q.out_y            <= '0;
					rsp_q.out_z            <= '0;
					rsp_q.out_inverse_mass <= '0;
				end
			end
			default: ;
		endcase
	end

	// Report status
	assign stat.operation  = item_q.operation;
	assign stat.wsum_zero  = (wa_q == 32'd0) && (wb_q == 32'd0);
	assign stat.s_zero     = s_q == 64'd0;
	assign stat.sqrt_last  = sq_cnt_q == 5'd31;
	assign stat.div_done   = div_done;
	assign stat.alpha_skip = alpha_zero || alpha_sat;
	assign stat.lm_sat     = lm_sat;

	assign rsp_item = rsp_q;
endmodule
`default_nettype wire

// ----- hdl/xpbd_ctrl.sv -----
// Controller: sequences memory access, arithmetic steps and the result register.
`timescale 1ns / 1ps
`default_nettype none
module xpbd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output xpbd_pkg::dp_cmd_t      cmd,
	input  wire xpbd_pkg::dp_stat_t stat
);
	import xpbd_pkg::*;

	typedef enum logic [21:0] {
		S_IDLE       = 22'd1 << 0,
		S_DECODE     = 22'd1 << 1,
		S_WRITE      = 22'd1 << 2,
		S_READ       = 22'd1 << 3,
		S_RDA        = 22'd1 << 4,
		S_RDB        = 22'd1 << 5,
		S_CAPB       = 22'd1 << 6,
		S_DELTA      = 22'd1 << 7,
		S_SQ         = 22'd1 << 8,
		S_SQRT_INIT  = 22'd1 << 9,
		S_SQRT       = 22'd1 << 10,
		S_DIST       = 22'd1 << 11,
		S_ALPHA      = 22'd1 << 12,
		S_ALPHA_WAIT = 22'd1 << 13,
		S_LM         = 22'd1 << 14,
		S_LM_WAIT    = 22'd1 << 15,
		S_DIR        = 22'd1 << 16,
		S_DIR_WAIT   = 22'd1 << 17,
		S_STEP       = 22'd1 << 18,
		S_MOVE       = 22'd1 << 19,
		S_STORE      = 22'd1 << 20,
		S_RESULT     = 22'd1 << 21
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic       end_q, end_d;
	logic [2:0] outcome_q, outcome_d;
	logic       valid_q;
	logic       load_result;

	assign req_ready   = state_q == S_IDLE;
	assign load_result = (state_q == S_RESULT) && (!valid_q || rsp_ready);

	// Next state and command
	always_comb begin
		state_d     = state_q;
		axis_d      = axis_q;
		end_d       = end_q;
		outcome_d   = outcome_q;
		cmd.code    = CMD_IDLE;
		cmd.axis    = axis_q;
		cmd.end_b   = end_q;
		cmd.outcome = outcome_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.code = CMD_LOAD;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (stat.operation == OP_WRITE) begin
					state_d = S_WRITE;
				end else if (stat.operation == OP_SOLVE) begin
					state_d = S_RDA;
				end else begin
					state_d = S_READ;
				end
			end
			S_WRITE: begin
				cmd.code  = CMD_WRITE;
				outcome_d = OUTCOME_WRITTEN;
				state_d   = S_RESULT;
			end
			S_READ: begin
				cmd.code  = CMD_READ_A;
				outcome_d = OUTCOME_READ;
				state_d   = S_RESULT;
			end
			S_RDA: begin
				cmd.code = CMD_READ_A;
				state_d  = S_RDB;
			end
			S_RDB: begin
				cmd.code = CMD_READ_B;
				state_d  = S_CAPB;
			end
			S_CAPB: begin
				cmd.code = CMD_CAP_B;
				state_d  = S_DELTA;
			end
			S_DELTA: begin
				cmd.code = CMD_DELTA;
				axis_d   = 2'd0;
				if (stat.wsum_zero) begin
					outcome_d = OUTCOME_PINNED;
					state_d   = S_RESULT;
				end else begin
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				cmd.code = CMD_SQUARE;
				axis_d   = axis_q + 2'd1;
				if (axis_q == 2'd2) begin
					state_d = S_SQRT_INIT;
				end
			end
			S_SQRT_INIT: begin
				if (stat.s_zero) begin
					outcome_d = OUTCOME_COINCIDENT;
					state_d   = S_RESULT;
				end else begin
					cmd.code = CMD_SQRT_INIT;
					state_d  = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.code = CMD_SQRT_STEP;
				if (stat.sqrt_last) begin
					state_d = S_DIST;
				end
			end
			S_DIST: begin
				cmd.code = CMD_DIST;
				state_d  = S_ALPHA;
			end
			S_ALPHA: begin
				cmd.code = CMD_ALPHA_START;
				state_d  = stat.alpha_skip ? S_LM : S_ALPHA_WAIT;
			end
			S_ALPHA_WAIT: begin
				cmd.code = CMD_ALPHA_WAIT;
				if (stat.div_done) begin
					state_d = S_LM;
				end
			end
			S_LM: begin
				cmd.code = CMD_LM_START;
				axis_d   = 2'd0;
				state_d  = stat.lm_sat ? S_DIR : S_LM_WAIT;
			end
			S_LM_WAIT: begin
				cmd.code = CMD_LM_WAIT;
				if (stat.div_done) begin
					state_d = S_DIR;
				end
			end
			S_DIR: begin
				cmd.code = CMD_DIR_START;
				state_d  = S_DIR_WAIT;
			end
			S_DIR_WAIT: begin
				cmd.code = CMD_DIR_WAIT;
				if (stat.div_done) begin
					if (axis_q == 2'd2) begin
						axis_d  = 2'd0;
						end_d   = 1'b0;
						state_d = S_STEP;
					end else begin
						axis_d  = axis_q + 2'd1;
						state_d = S_DIR;
					end
				end
			end
			S_STEP: begin
				cmd.code = CMD_STEP;
				axis_d   = 2'd0;
				state_d  = S_MOVE;
			end
			S_MOVE: begin
				cmd.code = CMD_MOVE;
				axis_d   = axis_q + 2'd1;
				if (axis_q == 2'd2) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.code = CMD_STORE;
				if (end_q) begin
					outcome_d = OUTCOME_APPLIED;
					state_d   = S_RESULT;
				end else begin
					end_d   = 1'b1;
					state_d = S_STEP;
				end
			end
			S_RESULT: begin
				if (load_result) begin
					cmd.code = CMD_RESULT;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			axis_q    <= '0;
			end_q     <= 1'b0;
			outcome_q <= OUTCOME_WRITTEN;
			valid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			axis_q    <= axis_d;
			end_q     <= end_d;
			outcome_q <= outcome_d;
			valid_q   <= load_result || (valid_q && !rsp_ready);
		end
	end

	assign rsp_valid = valid_q;
endmodule
`default_nettype wire

// ----- hdl/xpbd_distance_constraint_solver_top.sv -----
// Top level of the distance-constraint solver.
`timescale 1ns / 1ps
`default_nettype none
// Particle store with XPBD distance-constraint update, Q16.16 fixed point. One
// request is taken at a time; its result sits in an output register, so the
// next request is taken while that result waits. A write or read passes
// through decode, the memory access and the result state. A constraint is
// dominated by the bit-serial square root and the shared restoring divider,
// one quotient bit per cycle, for the compliance term, the multiplier and
// each of the three direction components. The compliance term is skipped
// when the compliance is zero or saturates, and the multiplier division when
// it saturates. Constraints end early when both ends are pinned or the ends
// coincide. Any item waits in its result state while the previous result is
// still not taken. The particle memory is a single port, one 128-bit word per
// particle. Entries never written read back as undefined data.
module xpbd_distance_constraint_solver_top #(
	parameter int PARTICLE_COUNT = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	xpbd_req_if.sink         req,
	xpbd_rsp_if.source       rsp,
	input  wire logic        cfg_write_enable,
	input  wire logic [31:0] cfg_write_data
);
	import xpbd_pkg::*;

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	req_item_t req_item;
	rsp_item_t rsp_item;

	// Pack the request payload
	assign req_item.operation         = req.operation;
	assign req_item.first_particle    = req.first_particle;
	assign req_item.second_particle   = req.second_particle;
	assign req_item.load_x            = req.load_x;
	assign req_item.load_y            = req.load_y;
	assign req_item.load_z            = req.load_z;
	assign req_item.load_inverse_mass = req.load_inverse_mass;
	assign req_item.rest_length       = req.rest_length;
	assign req_item.compliance        = req.compliance;

	xpbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	xpbd_dp #(
		.PARTICLE_COUNT (PARTICLE_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.req_item         (req_item),
		.rsp_item         (rsp_item),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data)
	);

	// Drive the result payload
	assign rsp.out_x            = rsp_item.out_x;
	assign rsp.out_y            = rsp_item.out_y;
	assign rsp.out_z            = rsp_item.out_z;
	assign rsp.out_inverse_mass = rsp_item.out_inverse_mass;
	assign rsp.outcome          = rsp_item.outcome;
endmodule
`default_nettype wire

// ----- verif/xpbd_distance_constraint_solver_top_tb.sv -----
// Self-checking testbench of the distance-constraint solver with a particle store predictor.
`timescale 1ns / 1ps
`default_nettype none
module xpbd_distance_constraint_solver_top_tb;
	import xpbd_pkg::*;

	localparam int PARTICLES = 1024;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_write_enable;
	logic [31:0] cfg_write_data;

	xpbd_req_if req ();
	xpbd_rsp_if rsp ();

	xpbd_distance_constraint_solver_top #(.PARTICLE_COUNT(PARTICLES)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg_write_enable(cfg_write_enable),
		.cfg_write_data(cfg_write_data)
	);

	// Predicted particle store and register
	logic [31:0] pos_x [PARTICLES];
	logic [31:0] pos_y [PARTICLES];
	logic [31:0] pos_z [PARTICLES];
	logic [31:0] inv_mass [PARTICLES];
	bit written [PARTICLES];
	logic [31:0] step_time;

	req_item_t pending_requests[$];
	rsp_item_t predicted_results[$];
	int mismatch_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int quiet_cycles;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
		if (v < -64'sh80000000) return -64'sh80000000;
		return v;
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Apply one constraint to the predicted store, return its outcome
	function automatic logic [2:0] solve_constraint(input req_item_t r);
		int unsigned a;
		int unsigned b;
		longint pa [3];
		longint pb [3];
		longint d [3];
		longint unsigned wa;
		longint unsigned wb;
		longint unsigned s;
		longint unsigned dist_val;
		longint unsigned alpha;
		longint unsigned dt2;
		longint unsigned lm;
		longint unsigned stepm;
		longint unsigned dm;
		longint unsigned w;
		longint unsigned comp;
		longint mv;
		longint p;
		longint c;
		bit lneg;
		bit neg;
		logic [31:0] np;
		a = r.first_particle;
		b = r.second_particle;
		wa = inv_mass[a];
		wb = inv_mass[b];
		if (wa + wb == 0) return OUTCOME_PINNED;
		s = 0;
		pa[0] = longint'($signed(pos_x[a]));
		pa[1] = longint'($signed(pos_y[a]));
		pa[2] = longint'($signed(pos_z[a]));
		pb[0] = longint'($signed(pos_x[b]));
		pb[1] = longint'($signed(pos_y[b]));
		pb[2] = longint'($signed(pos_z[b]));
		for (int i = 0; i < 3; i++) begin
			d[i] = clamp32(pb[i] - pa[i]);
			s += magnitude(d[i]) * magnitude(d[i]);
		end
		if (s == 0) return OUTCOME_COINCIDENT;
		dist_val = int_sqrt(s);
		c = longint'(dist_val) - longint'(r.rest_length);
		dt2 = longint'(step_time) * longint'(step_time);
		comp = r.compliance;
		if (comp == 0) alpha = 0;
		else if (dt2 == 0) alpha = 64'hFFFFFFFF;
		else begin
			alpha = (comp << 32) / dt2;
			if (alpha > 64'hFFFFFFFF) alpha = 64'hFFFFFFFF;
		end
		lm = (magnitude(c) << 16) / (wa + wb + alpha);
		if (lm > 64'h7FFFFFFF) lm = 64'h7FFFFFFF;
		lneg = c > 0;
		for (int e = 0; e < 2; e++) begin
			w = e == 0 ? wa : wb;
			stepm = (lm * w) >> 16;
			if (stepm > 64'h7FFFFFFF) stepm = 64'h7FFFFFFF;
			for (int i = 0; i < 3; i++) begin
				dm = (magnitude(d[i]) << 16) / dist_val;
				mv = longint'((dm * stepm) >> 16);
				neg = (d[i] < 0) ^ lneg ^ (e == 0);
				p = e == 0 ? pa[i] : pb[i];
				np = 32'(clamp32(p + (neg ? -mv : mv)));
				case (i)
					0: if (e == 0) pos_x[a] = np; else pos_x[b] = np;
					1: if (e == 0) pos_y[a] = np; else pos_y[b] = np;
					default: if (e == 0) pos_z[a] = np; else pos_z[b] = np;
				endcase
			end
		end
		return OUTCOME_APPLIED;
	endfunction

	// Predict the result of one request and queue it
	function automatic void predict_request(input req_item_t r);
		rsp_item_t res;
		res = '0;
		if (r.operation == OP_WRITE) begin
			pos_x[r.first_particle] = r.load_x;
			pos_y[r.first_particle] = r.load_y;
			pos_z[r.first_particle] = r.load_z;
			inv_mass[r.first_particle] = r.load_inverse_mass;
			res.outcome = OUTCOME_WRITTEN;
		end else if (r.operation == OP_SOLVE) begin
			res.outcome = solve_constraint(r);
		end else begin
			res.out_x = pos_x[r.first_particle];
			res.out_y = pos_y[r.first_particle];
			res.out_z = pos_z[r.first_particle];
			res.out_inverse_mass = inv_mass[r.first_particle];
			res.outcome = OUTCOME_READ;
		end
		predicted_results = {predicted_results, res};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// Driver: offer queued requests, predict at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				predict_request(pending_requests.pop_front());
			end
			if ((req.valid && !req.ready) ||
					(pending_requests.size() > 0 &&
					$urandom_range(99) >= send_idle_pct)) begin
				req.valid <= 1'b1;
				req.operation <= pending_requests[0].operation;
				req.first_particle <= pending_requests[0].first_particle;
				req.second_particle <= pending_requests[0].second_particle;
				req.load_x <= pending_requests[0].load_x;
				req.load_y <= pending_requests[0].load_y;
				req.load_z <= pending_requests[0].load_z;
				req.load_inverse_mass <= pending_requests[0].load_inverse_mass;
				req.rest_length <= pending_requests[0].rest_length;
				req.compliance <= pending_requests[0].compliance;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Monitor: check each result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("unexpected result", {29'd0, rsp.outcome}, 32'd0);
				end else begin
					want = predicted_results.pop_front();
					if (rsp.outcome !== want.outcome)
						report_mismatch("outcome", {29'd0, rsp.outcome}, {29'd0, want.outcome});
					if (rsp.out_x !== want.out_x) report_mismatch("out_x", rsp.out_x, want.out_x);
					if (rsp.out_y !== want.out_y) report_mismatch("out_y", rsp.out_y, want.out_y);
					if (rsp.out_z !== want.out_z) report_mismatch("out_z", rsp.out_z, want.out_z);
					if (rsp.out_inverse_mass !== want.out_inverse_mass)
						report_mismatch("out_inverse_mass", rsp.out_inverse_mass,
							want.out_inverse_mass);
				end
			end
			if (hold_cycles > 0) begin
				rsp.ready <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else begin
				rsp.ready <= $urandom_range(99) >= recv_stall_pct;
			end
			// Watchdog on cycles with no handshake
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Pick a particle: mostly a small working set, sometimes any
	function automatic logic [9:0] pick_particle();
		if ($urandom_range(9) < 8) return 10'($urandom_range(15));
		return 10'($urandom_range(PARTICLES - 1));
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom();
			default: return 32'($signed($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	function automatic logic [31:0] pick_mass();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			default: return $urandom_range(32'h0004_0000);
		endcase
	endfunction

	task automatic queue_request(input logic [1:0] op, input logic [9:0] a,
			input logic [9:0] b, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] m, input logic [30:0] rest,
			input logic [31:0] comp);
		req_item_t r;
		r.operation = op;
		r.first_particle = a;
		r.second_particle = b;
		r.load_x = x;
		r.load_y = y;
		r.load_z = z;
		r.load_inverse_mass = m;
		r.rest_length = rest;
		r.compliance = comp;
		// Never read or use an entry that was never written
		if (op != OP_WRITE && (!written[a] || (op == OP_SOLVE && !written[b]))) begin
			r.operation = OP_WRITE;
			r.load_inverse_mass = pick_mass();
		end
		if (r.operation == OP_WRITE) written[r.first_particle] = 1'b1;
		pending_requests = {pending_requests, r};
	endtask

	task automatic queue_random(input int count);
		logic [1:0] op;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0, 1, 2: op = OP_WRITE;
				3, 4, 5, 6: op = OP_SOLVE;
				default: op = OP_READ;
			endcase
			queue_request(op, pick_particle(), pick_particle(), pick_coord(), pick_coord(),
				pick_coord(), pick_mass(),
				$urandom_range(3) == 0 ? 31'($urandom()) : 31'($urandom_range(32'h0020_0000)),
				$urandom_range(2) == 0 ? 32'd0 :
				($urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h100)));
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || req.valid || predicted_results.size() != 0)
			@(posedge clk);
		// Let a skipped constraint's tail settle
		repeat (250) @(posedge clk);
	endtask

	task automatic write_time_step(input logic [31:0] value);
		cfg_write_enable <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_enable <= 1'b0;
		step_time = value;
	endtask

	initial begin
		mismatch_count = 0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		step_time = TIME_STEP_RESET;
		cfg_write_enable = 1'b0;
		cfg_write_data = '0;
		req.valid = 1'b0;
		req.operation = '0;
		req.first_particle = '0;
		req.second_particle = '0;
		req.load_x = '0;
		req.load_y = '0;
		req.load_z = '0;
		req.load_inverse_mass = '0;
		req.rest_length = '0;
		req.compliance = '0;
		rsp.ready = 1'b0;
		foreach (written[i]) written[i] = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, both ends pinned, coincident ends, same particle
		queue_request(OP_WRITE, 10'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
			32'hFFFF_FFFF, '0, '0);
		queue_request(OP_WRITE, 10'd1023, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'd0, '0, '0);
		queue_request(OP_WRITE, 10'd2, 10'd0, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000,
			'0, '0);
		queue_request(OP_WRITE, 10'd3, 10'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, '0, '0);
		queue_request(OP_WRITE, 10'd4, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0, '0, '0);
		queue_request(OP_READ, 10'd0, 10'd0, '0, '0, '0, '0, '0, '0);
		queue_request(OP_READ, 10'd1023, 10'd0, '0, '0, '0, '0, '0, '0);
		queue_request(OP_SOLVE, 10'd1023, 10'd4, '0, '0, '0, '0, '0, '0);
		queue_request(OP_SOLVE, 10'd2, 10'd3, '0, '0, '0, '0, '0, '0);
		queue_request(OP_SOLVE, 10'd2, 10'd2, '0, '0, '0, '0, '0, '0);
		queue_request(OP_SOLVE, 10'd0, 10'd1023, '0, '0, '0, '0, 31'h7FFF_FFFF,
			32'hFFFF_FFFF);
		queue_request(OP_SOLVE, 10'd0, 10'd2, '0, '0, '0, '0, 31'd0, 32'd0);
		queue_request(OP_SOLVE, 10'd4, 10'd2, '0, '0, '0, '0, 31'h0000_8000, 32'h0000_0100);
		queue_request(OP_READ, 10'd0, 10'd0, '0, '0, '0, '0, '0, '0);
		queue_request(OP_READ, 10'd2, 10'd0, '0, '0, '0, '0, '0, '0);
		queue_request(OP_READ, 10'd4, 10'd0, '0, '0, '0, '0, '0, '0);
		queue_request(2'd3, 10'd2, 10'd0, '0, '0, '0, '0, '0, '0);
		wait_drained();

		// Random phases over several time steps and idling mixes
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_time_step(32'd1);
				1: write_time_step(32'hFFFF_FFFF);
				2: write_time_step(32'd0);
				3: write_time_step($urandom());
				default: write_time_step(TIME_STEP_RESET);
			endcase
			case (phase)
				1: begin send_idle_pct = 79; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 79; end
				3: begin send_idle_pct = 13; recv_stall_pct = 13; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (phase == 4) hold_cycles = 2000;
			queue_random(200);
			wait_drained();
		end

		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
